// File: rtl/core/pidc_pkg.sv
package pidc_pkg;

  // payload and register widths
  localparam int ErrW  = 16;
  localparam int StepW = 16;
  localparam int GainW = 24;
  localparam int LimW  = 32;
  localparam int IdxW  = 3;

  // datapath widths
  localparam int FracW = 12;                 // error scaling before the divide
  localparam int DivW  = StepW + FracW;      // magnitude of (error delta * 1.0)
  localparam int DerW  = DivW + 1;           // signed derivative
  localparam int CntW  = $clog2(DivW);
  localparam int MulAW = GainW + 1;
  localparam int MulBW = DerW;
  localparam int ProdW = MulAW + MulBW;
  localparam int IntW  = 48;
  localparam int IntHW = IntW / 2;           // integral split point (Q.24)
  localparam int AccW  = 50;
  localparam int PcW   = 4;

  localparam logic [StepW-1:0] OneQ12 = StepW'(4096);

  // register indexes
  localparam logic [IdxW-1:0] RegKp     = IdxW'(0);
  localparam logic [IdxW-1:0] RegKi     = IdxW'(1);
  localparam logic [IdxW-1:0] RegKd     = IdxW'(2);
  localparam logic [IdxW-1:0] RegOutMax = IdxW'(3);
  localparam logic [IdxW-1:0] RegOutMin = IdxW'(4);

  // microprogram addresses
  localparam logic [PcW-1:0] StepWaitIn = PcW'(0);
  localparam logic [PcW-1:0] StepDiv    = PcW'(1);
  localparam logic [PcW-1:0] StepDerFix = PcW'(2);
  localparam logic [PcW-1:0] StepIntUpd = PcW'(3);
  localparam logic [PcW-1:0] StepAddP   = PcW'(4);
  localparam logic [PcW-1:0] StepAddD   = PcW'(5);
  localparam logic [PcW-1:0] StepAddIhi = PcW'(6);
  localparam logic [PcW-1:0] StepAddIlo = PcW'(7);
  localparam logic [PcW-1:0] StepEmit   = PcW'(8);

  typedef enum logic [2:0] {
    MUL_NONE     = 3'd0,
    MUL_ERR_STEP = 3'd1,
    MUL_KP_ERR   = 3'd2,
    MUL_KD_DER   = 3'd3,
    MUL_KI_HI    = 3'd4,
    MUL_KI_LO    = 3'd5
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD   = 3'd0,
    ACC_CLR    = 3'd1,
    ACC_ADD_Q0 = 3'd2,
    ACC_ADD_Q12 = 3'd3,
    ACC_ADD_Q24 = 3'd4
  } acc_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_WAIT_IN  = 2'd1,
    JMP_DIV_LOOP = 2'd2,
    JMP_WAIT_OUT = 2'd3
  } jmp_e;

  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     div_fix;
    logic     int_upd;
    logic     emit;
    mul_sel_e mul;
    acc_op_e  acc;
    jmp_e     jmp;
  } uop_t;

  typedef struct packed {
    logic in_valid;
    logic div_last;
    logic out_free;
  } stat_t;

  // control store
  function automatic uop_t ucode(input logic [PcW-1:0] pc);
    uop_t u;
    u = '0;
    case (pc)
      StepWaitIn: begin
        u.load = 1'b1;
        u.jmp  = JMP_WAIT_IN;
      end
      StepDiv: begin
        u.div_step = 1'b1;
        u.jmp      = JMP_DIV_LOOP;
      end
      StepDerFix: begin
        u.div_fix = 1'b1;
        u.mul     = MUL_ERR_STEP;
      end
      StepIntUpd: begin
        u.int_upd = 1'b1;
        u.mul     = MUL_KP_ERR;
        u.acc     = ACC_CLR;
      end
      StepAddP: begin
        u.mul = MUL_KD_DER;
        u.acc = ACC_ADD_Q12;
      end
      StepAddD: begin
        u.mul = MUL_KI_HI;
        u.acc = ACC_ADD_Q12;
      end
      StepAddIhi: begin
        u.mul = MUL_KI_LO;
        u.acc = ACC_ADD_Q0;
      end
      StepAddIlo: begin
        u.acc = ACC_ADD_Q24;
      end
      StepEmit: begin
        u.emit = 1'b1;
        u.jmp  = JMP_WAIT_OUT;
      end
      default: begin
        u.jmp = JMP_WAIT_OUT;
      end
    endcase
    return u;
  endfunction

endpackage

// File: rtl/core/pidc_if.sv
interface pidc_in_if import pidc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ErrW-1:0] error_sample;
  logic [StepW-1:0]       delta_time;

  modport source (output valid, error_sample, delta_time, input ready);
  modport sink (input valid, error_sample, delta_time, output ready);
endinterface

interface pidc_out_if import pidc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [LimW-1:0] control;
  logic [StepW-1:0]       applied_step;

  modport source (output valid, control, applied_step, input ready);
  modport sink (input valid, control, applied_step, output ready);
endinterface

interface pidc_cfg_if import pidc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] index;
  logic [LimW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/pidc_seq.sv
module pidc_seq import pidc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output uop_t  uop_o,
  output logic  go_o
);

  logic [PcW-1:0] pc_q, pc_d;
  uop_t           uop;

  assign uop = ucode(pc_q);

  always_comb begin
    go_o = 1'b1;
    pc_d = pc_q + PcW'(1);
    case (uop.jmp)
      JMP_NEXT: begin
        go_o = 1'b1;
      end
      JMP_WAIT_IN: begin
        go_o = stat_i.in_valid;
        if (!go_o) pc_d = pc_q;
      end
      JMP_DIV_LOOP: begin
        go_o = stat_i.div_last;
        if (!go_o) pc_d = pc_q;
      end
      JMP_WAIT_OUT: begin
        go_o = stat_i.out_free;
        pc_d = go_o ? StepWaitIn : pc_q;
      end
      default: begin
        pc_d = StepWaitIn;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepWaitIn;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign uop_o = uop;

endmodule

// File: rtl/core/pidc_dp.sv
module pidc_dp import pidc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [IdxW-1:0]        cfg_idx_i,
  input  logic [LimW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  input  logic signed [ErrW-1:0] err_i,
  input  logic [StepW-1:0]       dt_i,
  input  logic                   out_ready_i,
  input  uop_t                   uop_i,
  input  logic                   go_i,
  output stat_t                  stat_o,
  output logic                   out_valid_o,
  output logic signed [LimW-1:0] control_o,
  output logic [StepW-1:0]       applied_step_o
);

  // configuration
  logic signed [GainW-1:0] kp_q, ki_q, kd_q;
  logic signed [LimW-1:0]  out_max_q, out_min_q;

  // state carried between words
  logic signed [ErrW-1:0]  last_err_q;
  logic signed [IntW-1:0]  integ_q;

  // per-word working registers
  logic signed [ErrW-1:0]  err_q;
  logic [StepW-1:0]        step_q;
  logic                    neg_q;
  logic [StepW-1:0]        rem_q;
  logic [DivW-1:0]         quo_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [DerW-1:0]  deriv_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;

  // result register
  logic                    out_valid_q;
  logic signed [LimW-1:0]  out_ctl_q;
  logic [StepW-1:0]        out_step_q;

  logic                    load, emit, out_free;
  logic [StepW-1:0]        step_in;
  logic signed [ErrW:0]    diff;
  logic [ErrW:0]           diff_mag;
  logic [StepW:0]          rem_sh;
  logic                    q_bit;
  logic [DerW-1:0]         quo_ext;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [IntW:0]    int_sum;
  logic signed [IntW-1:0]  int_sat;
  logic signed [AccW-1:0]  acc_add;
  logic signed [AccW-1:0]  lim_hi, lim_lo;
  logic signed [LimW-1:0]  ctl_clamped;

  assign out_free = !out_valid_q || out_ready_i;
  assign load     = uop_i.load && go_i;
  assign emit     = uop_i.emit && go_i;

  assign stat_o = '{in_valid: in_valid_i, div_last: (cnt_q == '0), out_free: out_free};

  // zero step means 1.0
  assign step_in  = (dt_i == '0) ? OneQ12 : dt_i;
  assign diff     = (ErrW+1)'(err_i) - (ErrW+1)'(last_err_q);
  assign diff_mag = diff[ErrW] ? (~diff + (ErrW+1)'(1)) : diff;

  // restoring divider, one quotient bit per cycle
  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign q_bit   = (rem_sh >= {1'b0, step_q});
  assign quo_ext = {1'b0, quo_q};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uop_i.mul)
      MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MUL_ERR_STEP: begin
        mul_a = MulAW'(err_q);
        mul_b = MulBW'($signed({1'b0, step_q}));
      end
      MUL_KP_ERR: begin
        mul_a = MulAW'(kp_q);
        mul_b = MulBW'(err_q);
      end
      MUL_KD_DER: begin
        mul_a = MulAW'(kd_q);
        mul_b = deriv_q;
      end
      MUL_KI_HI: begin
        mul_a = MulAW'(ki_q);
        mul_b = MulBW'($signed(integ_q[IntW-1:IntHW]));
      end
      MUL_KI_LO: begin
        mul_a = MulAW'(ki_q);
        mul_b = MulBW'($signed({1'b0, integ_q[IntHW-1:0]}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // saturating integral
  assign int_sum = (IntW+1)'(integ_q) + (IntW+1)'(prod_q);
  assign int_sat = (int_sum[IntW] != int_sum[IntW-1]) ?
                   {int_sum[IntW], {(IntW-1){~int_sum[IntW]}}} : int_sum[IntW-1:0];

  always_comb begin
    acc_add = '0;
    case (uop_i.acc)
      ACC_ADD_Q0:  acc_add = AccW'(prod_q);
      ACC_ADD_Q12: acc_add = AccW'(prod_q >>> 12);
      ACC_ADD_Q24: acc_add = AccW'(prod_q >>> IntHW);
      default:     acc_add = '0;
    endcase
  end

  // clamp, low limit checked first
  assign lim_hi = AccW'(out_max_q);
  assign lim_lo = AccW'(out_min_q);
  assign ctl_clamped = (acc_q < lim_lo) ? out_min_q :
                       (acc_q > lim_hi) ? out_max_q : acc_q[LimW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      out_max_q   <= LimW'(65536);
      out_min_q   <= -LimW'(65536);
      last_err_q  <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegKp:     kp_q      <= cfg_data_i[GainW-1:0];
          RegKi:     ki_q      <= cfg_data_i[GainW-1:0];
          RegKd:     kd_q      <= cfg_data_i[GainW-1:0];
          RegOutMax: out_max_q <= cfg_data_i;
          RegOutMin: out_min_q <= cfg_data_i;
          default:   ;
        endcase
      end
      if (load) last_err_q <= err_i;
      if (uop_i.int_upd) integ_q <= int_sat;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      err_q  <= err_i;
      step_q <= step_in;
      neg_q  <= diff[ErrW];
      rem_q  <= '0;
      quo_q  <= {diff_mag[StepW-1:0], {FracW{1'b0}}};
      cnt_q  <= CntW'(DivW - 1);
    end else if (uop_i.div_step) begin
      rem_q <= q_bit ? StepW'(rem_sh - {1'b0, step_q}) : rem_sh[StepW-1:0];
      quo_q <= {quo_q[DivW-2:0], q_bit};
      cnt_q <= cnt_q - CntW'(1);
    end
    if (uop_i.div_fix) deriv_q <= neg_q ? (~quo_ext + DerW'(1)) : quo_ext;
    if (uop_i.mul != MUL_NONE) prod_q <= mul_a * mul_b;
    case (uop_i.acc)
      ACC_HOLD: ;
      ACC_CLR:  acc_q <= '0;
      default:  acc_q <= acc_q + acc_add;
    endcase
    if (emit) begin
      out_ctl_q  <= ctl_clamped;
      out_step_q <= step_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign control_o      = out_ctl_q;
  assign applied_step_o = out_step_q;

endmodule

// File: rtl/core/pid_controller_clamped.sv
// fixed-point pid controller with output clamp. each input word carries an
// error sample (signed q3.12) and a time step (unsigned q4.12, zero means 1.0).
// the block returns one word per input: kp*e + kd*de/dt + ki*integral in
// signed q16.16, clamped to [out_min, out_max] (low limit checked first), and
// the time step actually used. the derivative divide truncates toward zero,
// the integral saturates at 48 bits, products are floored. from acceptance to
// the result register a word passes one load step, 28 steps of the radix-2
// divider loop, then seven steps that share one 25x29 multiplier and an
// accumulator. the next word is accepted the cycle after the result is
// loaded, so a new word is not taken before the last one is done. a finished
// word waits in the output register; if it is still there when the next one
// is done, the sequencer holds on its last step. gains and limits are written
// through the configuration channel, which is always ready; writes to an
// unknown index are dropped. reset clears the stored error and the integral
// and loads the register defaults.
module pid_controller_clamped import pidc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pidc_cfg_if.sink   cfg_i,
  pidc_in_if.sink    in_i,
  pidc_out_if.source out_o
);

  uop_t  uop;
  logic  go;
  stat_t stat;

  // configuration is a plain register write
  assign cfg_i.ready = 1'b1;

  // input is taken only on the first microprogram step
  assign in_i.ready = uop.load;

  // control store and step counter
  pidc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .uop_o  (uop),
    .go_o   (go)
  );

  // divider, multiplier, accumulator, state and result register
  pidc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_i.valid),
    .cfg_idx_i      (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .in_valid_i     (in_i.valid),
    .err_i          (in_i.error_sample),
    .dt_i           (in_i.delta_time),
    .out_ready_i    (out_o.ready),
    .uop_i          (uop),
    .go_i           (go),
    .stat_o         (stat),
    .out_valid_o    (out_o.valid),
    .control_o      (out_o.control),
    .applied_step_o (out_o.applied_step)
  );

  // one word at a time: no second accept right after the first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted on back-to-back cycles");

  // a result only appears when the emit step completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(uop.emit && go))
    else $error("output valid without emit step");

  // the applied step is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.applied_step != '0))
    else $error("zero applied step on output");

endmodule
